// File: rtl/extended_opcode_decoder_macros.svh
// ----------------------------------------------------------------------------
// Extended opcode decoder assertion macros
// Concurrent assertion wrappers that compile away when ASSERT_OFF is defined.
// ----------------------------------------------------------------------------
`ifndef EXTENDED_OPCODE_DECODER_MACROS_SVH
`define EXTENDED_OPCODE_DECODER_MACROS_SVH

`ifndef ASSERT_OFF
// Checked on every rising edge while reset is released.
`define EOD_ASSERT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);
// Checked on every rising edge, reset included.
`define EOD_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define EOD_ASSERT(lbl, clk, rstn, prop, msg)
`define EOD_ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif

`endif

// File: rtl/eod_pkg.sv
// ----------------------------------------------------------------------------
// Extended opcode decoder package
// Field widths, operand form and mnemonic codes, and small decode tables.
// ----------------------------------------------------------------------------
package eod_pkg;

  localparam int unsigned WordW = 16;
  localparam int unsigned HdW   = 7;
  localparam int unsigned MnW   = 6;
  localparam int unsigned FmW   = 4;
  localparam int unsigned RegW  = 5;
  localparam int unsigned ImmW  = 20;

  // Operand forms.
  localparam logic [FmW-1:0] FM_LD2 = 4'd0;
  localparam logic [FmW-1:0] FM_ST2 = 4'd1;
  localparam logic [FmW-1:0] FM_RRI = 4'd2;
  localparam logic [FmW-1:0] FM_RI  = 4'd3;
  localparam logic [FmW-1:0] FM_RRR = 4'd4;
  localparam logic [FmW-1:0] FM_RR  = 4'd5;
  localparam logic [FmW-1:0] FM_LD  = 4'd6;
  localparam logic [FmW-1:0] FM_ST  = 4'd7;

  // Mnemonics referenced by name.
  localparam logic [MnW-1:0] MN_ADDI   = 6'd4;
  localparam logic [MnW-1:0] MN_SHLI   = 6'd9;
  localparam logic [MnW-1:0] MN_SHRI   = 6'd10;
  localparam logic [MnW-1:0] MN_SARI   = 6'd11;
  localparam logic [MnW-1:0] MN_LDCTI  = 6'd12;
  localparam logic [MnW-1:0] MN_LDCTF  = 6'd14;
  localparam logic [MnW-1:0] MN_ADDQ   = 6'd16;
  localparam logic [MnW-1:0] MN_ADDF   = 6'd25;
  localparam logic [MnW-1:0] MN_SHRQ   = 6'd29;
  localparam logic [MnW-1:0] MN_MOVV   = 6'd42;
  localparam logic [MnW-1:0] MN_LDC20I = 6'd43;

  // Handler numbering anchors.
  localparam logic [HdW-1:0] HD_SHLI      = 7'd13;
  localparam logic [HdW-1:0] HD_SHRI      = 7'd14;
  localparam logic [HdW-1:0] HD_SARI      = 7'd15;
  localparam logic [HdW-1:0] HD_LDCT_INT  = 7'd16;
  localparam logic [HdW-1:0] HD_LDCT_FLT  = 7'd18;
  localparam logic [HdW-1:0] HD_SUB1_BASE = 7'd20;
  localparam logic [HdW-1:0] HD_FPU_BASE  = 7'd36;
  localparam logic [HdW-1:0] HD_SUB2_BASE = 7'd33;
  localparam logic [HdW-1:0] HD_SUB3_LO   = 7'd53;
  localparam logic [HdW-1:0] HD_MOVV_LD2  = 7'd58;
  localparam logic [HdW-1:0] HD_MOVV_ST2  = 7'd59;
  localparam logic [HdW-1:0] HD_SUB3_HI   = 7'd52;
  localparam logic [HdW-1:0] HD_MOVV_LD   = 7'd65;
  localparam logic [HdW-1:0] HD_MOVV_ST   = 7'd66;
  localparam logic [HdW-1:0] HD_LDC20I    = 7'd67;
  localparam logic [HdW-1:0] HD_MAX       = 7'd81;

  localparam logic [MnW-1:0] MN_SUB2_OFS  = 6'd22;

  // Group and subgroup selectors.
  localparam logic [3:0] GRP_E0 = 4'd0;
  localparam logic [3:0] GRP_E1 = 4'd1;
  localparam logic [3:0] GRP_E2 = 4'd2;
  localparam logic [3:0] SUB_MEM  = 4'd0;
  localparam logic [3:0] SUB_WIDE = 4'd1;
  localparam logic [3:0] SUB_UNA  = 4'd2;
  localparam logic [3:0] SUB_IMM  = 4'd3;
  localparam logic [7:0] SEL_MIN  = 8'h07;
  localparam logic [7:0] SEL_MAX  = 8'h13;

  // Wide register-register ops: quad and word mnemonics.
  localparam logic [MnW-1:0] SUB1_MN_Q [8] = '{6'd16, 6'd18, 6'd19, 6'd20,
                                               6'd21, 6'd22, 6'd23, 6'd24};
  localparam logic [MnW-1:0] SUB1_MN_W [8] = '{6'd4, 6'd17, 6'd5, 6'd6,
                                               6'd7, 6'd8, 6'd9, 6'd11};

  // Group E2 tables, indexed by bits 15:12 of the second word.
  localparam logic [MnW-1:0] G2_MN [16] = '{6'd0, 6'd1, 6'd2, 6'd3, 6'd0, 6'd1, 6'd2, 6'd3,
                                            6'd44, 6'd45, 6'd44, 6'd45,
                                            6'd46, 6'd47, 6'd48, 6'd49};
  localparam logic [FmW-1:0] G2_FM [16] = '{FM_LD, FM_LD, FM_LD, FM_LD,
                                            FM_ST, FM_ST, FM_ST, FM_ST,
                                            FM_LD, FM_LD, FM_ST, FM_ST,
                                            FM_LD, FM_LD, FM_LD, FM_LD};
  localparam logic [HdW-1:0] G2_HD [16] = '{7'd68, 7'd69, 7'd70, 7'd71,
                                            7'd72, 7'd73, 7'd74, 7'd75,
                                            7'd76, 7'd71, 7'd77, 7'd75,
                                            7'd78, 7'd79, 7'd80, 7'd81};

  // One decoded instruction.
  typedef struct packed {
    logic                   recognized;
    logic [HdW-1:0]         handler_id;
    logic [MnW-1:0]         mnemonic_id;
    logic [FmW-1:0]         operand_form;
    logic [RegW-1:0]        dest_reg;
    logic [RegW-1:0]        src_reg;
    logic [RegW-1:0]        index_reg;
    logic                   dest_is_float;
    logic                   src_is_float;
    logic signed [ImmW-1:0] immediate;
  } dec_res_t;

endpackage

// File: rtl/extended_opcode_decoder.sv
// ----------------------------------------------------------------------------
// Extended opcode decoder
// Decodes one 32-bit extended instruction per transfer into handler,
// mnemonic, operand form, register numbers and an extended immediate.
// ----------------------------------------------------------------------------
//
//   channel  | direction | tdata                         | tuser
//   ---------+-----------+-------------------------------+------------
//   s_axis   | in        | first_word, second_word       | none
//   m_axis   | out       | decoded fields (see port)     | recognized
//
// Each instruction passes through the input register and then the result
// register. The decode logic between them is a single pass, so one
// transfer is taken every cycle when the output side keeps up. Reset clears
// only the two stage valid flags. A stall on the master side backs up
// through the result register and the input register; the input side keeps
// accepting while either stage has room.
`include "extended_opcode_decoder_macros.svh"

module extended_opcode_decoder (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  // [15:0] first_word, [31:16] second_word
  input  logic [31:0] s_axis_tdata_i,
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  // [6:0] handler_id, [12:7] mnemonic_id, [16:13] operand_form,
  // [21:17] dest_reg, [26:22] src_reg, [31:27] index_reg,
  // [32] dest_is_float, [33] src_is_float, [53:34] immediate, [55:54] zero
  output logic [55:0] m_axis_tdata_o,
  // [0] recognized
  output logic        m_axis_tuser_o
);

  // Input stage.
  logic                           in_valid_q;
  logic [eod_pkg::WordW-1:0]      w1_q, w2_q;
  // Result stage.
  logic                           out_valid_q;
  eod_pkg::dec_res_t              res_q, res_d;

  logic in_fire, adv;

  // The result register moves when empty or drained this cycle; the input
  // register can load whenever it is empty or passing its item on.
  assign adv             = in_valid_q && (!out_valid_q || m_axis_tready_i);
  assign s_axis_tready_o = !in_valid_q || !out_valid_q || m_axis_tready_i;
  assign in_fire         = s_axis_tvalid_i && s_axis_tready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (in_fire) begin
        in_valid_q <= 1'b1;
      end else if (adv) begin
        in_valid_q <= 1'b0;
      end
      if (adv) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      w1_q <= s_axis_tdata_i[15:0];
      w2_q <= s_axis_tdata_i[31:16];
    end
    if (adv) begin
      res_q <= res_d;
    end
  end

  // --------------------------------------------------------------------------
  // Decode. Field nibbles: grp/sub/lo from the first word, a/b/c from the
  // second word's upper three nibbles.
  // --------------------------------------------------------------------------
  logic [3:0]  grp, sub, lo, a, b, c;
  logic [7:0]  sel;
  logic [1:0]  kind;
  logic        qflag;
  logic        ok;
  logic [19:0] sx8, sx12, zx8, zx12;

  assign grp   = w1_q[11:8];
  assign sub   = w1_q[7:4];
  assign lo    = w1_q[3:0];
  assign a     = w2_q[15:12];
  assign b     = w2_q[11:8];
  assign c     = w2_q[7:4];
  assign sel   = w2_q[15:8];
  assign kind  = w1_q[7:6];
  assign qflag = w2_q[11];
  assign sx8   = {{12{w2_q[7]}}, w2_q[7:0]};
  assign sx12  = {{8{w2_q[11]}}, w2_q[11:0]};
  assign zx8   = {12'd0, w2_q[7:0]};
  assign zx12  = {8'd0, w2_q[11:0]};

  always_comb begin
    eod_pkg::dec_res_t r;
    r  = '0;
    ok = 1'b1;
    if (grp == eod_pkg::GRP_E0 && sub == eod_pkg::SUB_MEM) begin
      r.dest_reg = {1'b0, a};
      if (!lo[3]) begin
        // Scaled-index loads and stores with a 4-bit displacement.
        if (!lo[2]) begin
          r.src_reg      = {1'b0, b};
          r.index_reg    = {1'b0, c};
          r.operand_form = eod_pkg::FM_LD2;
        end else begin
          r.index_reg    = {1'b0, b};
          r.src_reg      = {1'b0, c};
          r.operand_form = eod_pkg::FM_ST2;
        end
        r.immediate   = {16'd0, w2_q[3:0]};
        r.mnemonic_id = {4'd0, lo[1:0]};
        r.handler_id  = {3'd0, lo};
      end else if (lo < 4'd13) begin
        r.src_reg      = {1'b0, b};
        r.operand_form = eod_pkg::FM_RRI;
        r.immediate    = (lo < 4'd10) ? sx8 : zx8;
        r.mnemonic_id  = {2'd0, lo} - eod_pkg::MN_ADDI;
        r.handler_id   = {3'd0, lo};
      end else if (lo == 4'd13) begin
        // The shift kind lives in bits that are zero here: always a left shift.
        r.src_reg      = {1'b0, b};
        r.operand_form = eod_pkg::FM_RRI;
        r.immediate    = {14'd0, w2_q[5:0]};
        if (!kind[1]) begin
          r.mnemonic_id = eod_pkg::MN_SHLI;
          r.handler_id  = eod_pkg::HD_SHLI;
        end else if (!kind[0]) begin
          r.mnemonic_id = eod_pkg::MN_SHRI;
          r.handler_id  = eod_pkg::HD_SHRI;
        end else begin
          r.mnemonic_id = eod_pkg::MN_SARI;
          r.handler_id  = eod_pkg::HD_SARI;
        end
      end else begin
        r.operand_form = eod_pkg::FM_RI;
        r.immediate    = {9'd0, w2_q[10:0]};
        if (lo == 4'd14) begin
          r.mnemonic_id = eod_pkg::MN_LDCTI + {5'd0, qflag};
          r.handler_id  = eod_pkg::HD_LDCT_INT + {6'd0, qflag};
        end else begin
          r.mnemonic_id = eod_pkg::MN_LDCTF + {5'd0, qflag};
          r.handler_id  = eod_pkg::HD_LDCT_FLT + {6'd0, qflag};
        end
      end
    end else if (grp == eod_pkg::GRP_E0 && sub == eod_pkg::SUB_WIDE) begin
      if (lo < 4'd12) begin
        // Bits 14, 13 and 12 of the first word extend ro, rn and rm.
        r.index_reg    = {w1_q[14], b};
        r.dest_reg     = {w1_q[13], c};
        r.src_reg      = {w1_q[12], w2_q[3:0]};
        r.operand_form = eod_pkg::FM_RRR;
        if (!lo[3]) begin
          r.mnemonic_id = qflag ? eod_pkg::SUB1_MN_Q[lo[2:0]] : eod_pkg::SUB1_MN_W[lo[2:0]];
          r.handler_id  = eod_pkg::HD_SUB1_BASE + {3'd0, lo[2:0], !qflag};
        end else begin
          r.mnemonic_id = eod_pkg::MN_ADDF + {4'd0, lo[1:0]};
          r.handler_id  = eod_pkg::HD_FPU_BASE + {5'd0, lo[1:0]};
        end
      end else begin
        ok = 1'b0;
      end
    end else if (grp == eod_pkg::GRP_E0 && sub == eod_pkg::SUB_UNA) begin
      if (lo == 4'd0 && sel >= eod_pkg::SEL_MIN && sel <= eod_pkg::SEL_MAX) begin
        r.dest_reg     = {1'b0, c};
        r.src_reg      = {1'b0, w2_q[3:0]};
        r.operand_form = eod_pkg::FM_RR;
        r.mnemonic_id  = sel[5:0] + eod_pkg::MN_SUB2_OFS;
        r.handler_id   = sel[6:0] + eod_pkg::HD_SUB2_BASE;
      end else begin
        ok = 1'b0;
      end
    end else if (grp == eod_pkg::GRP_E0 && sub == eod_pkg::SUB_IMM) begin
      r.dest_reg = {1'b0, a};
      if (lo <= 4'd4) begin
        r.operand_form = eod_pkg::FM_RI;
        r.immediate    = (lo < 4'd2) ? sx12 : zx12;
        r.mnemonic_id  = eod_pkg::MN_ADDI + {2'd0, lo};
        r.handler_id   = eod_pkg::HD_SUB3_LO + {3'd0, lo};
      end else if (lo == 4'd6 || lo == 4'd7) begin
        if (lo == 4'd6) begin
          r.src_reg      = {1'b0, b};
          r.index_reg    = {1'b0, c};
          r.operand_form = eod_pkg::FM_LD2;
          r.handler_id   = eod_pkg::HD_MOVV_LD2;
        end else begin
          r.index_reg    = {1'b0, b};
          r.src_reg      = {1'b0, c};
          r.operand_form = eod_pkg::FM_ST2;
          r.handler_id   = eod_pkg::HD_MOVV_ST2;
        end
        r.immediate   = {16'd0, w2_q[3:0]};
        r.mnemonic_id = eod_pkg::MN_MOVV;
      end else if (lo >= 4'd8 && lo <= 4'd12) begin
        r.operand_form = eod_pkg::FM_RI;
        r.immediate    = (lo < 4'd10) ? sx12 : zx12;
        // ADDQ is not adjacent to the rest of its row.
        r.mnemonic_id  = (lo == 4'd8) ? eod_pkg::MN_ADDQ : ({2'd0, lo} + 6'd10);
        r.handler_id   = eod_pkg::HD_SUB3_HI + {3'd0, lo};
      end else if (lo == 4'd14 || lo == 4'd15) begin
        r.src_reg      = {1'b0, b};
        r.immediate    = sx8;
        r.mnemonic_id  = eod_pkg::MN_MOVV;
        r.operand_form = (lo == 4'd14) ? eod_pkg::FM_LD : eod_pkg::FM_ST;
        r.handler_id   = (lo == 4'd14) ? eod_pkg::HD_MOVV_LD : eod_pkg::HD_MOVV_ST;
      end else begin
        ok = 1'b0;
      end
    end else if (grp == eod_pkg::GRP_E1) begin
      // 20-bit constant load: rn rides in the top nibble of the first word.
      r.dest_reg     = {1'b0, w1_q[15:12]};
      r.immediate    = {lo, w2_q};
      r.operand_form = eod_pkg::FM_RI;
      r.mnemonic_id  = eod_pkg::MN_LDC20I;
      r.handler_id   = eod_pkg::HD_LDC20I;
    end else if (grp == eod_pkg::GRP_E2) begin
      r.dest_reg      = {1'b0, sub};
      r.src_reg       = {1'b0, lo};
      r.immediate     = sx12;
      r.mnemonic_id   = eod_pkg::G2_MN[a];
      r.operand_form  = eod_pkg::G2_FM[a];
      r.handler_id    = eod_pkg::G2_HD[a];
      r.dest_is_float = (a == 4'd8) || (a == 4'd9);
      r.src_is_float  = (a == 4'd10) || (a == 4'd11);
    end else begin
      ok = 1'b0;
    end

    if (!ok) begin
      r = '0;
    end
    r.recognized = ok;
    res_d        = r;
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tuser_o  = res_q.recognized;
  assign m_axis_tdata_o  = {2'b00, res_q.immediate, res_q.src_is_float, res_q.dest_is_float,
                            res_q.index_reg, res_q.src_reg, res_q.dest_reg,
                            res_q.operand_form, res_q.mnemonic_id, res_q.handler_id};

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
  `EOD_ASSERT(a_unrec_zero, clk_i, rst_ni, out_valid_q && !res_q.recognized |-> res_q == '0, "unrecognized result carries nonzero fields")
  `EOD_ASSERT(a_hd_range, clk_i, rst_ni, out_valid_q && res_q.recognized |-> res_q.handler_id <= eod_pkg::HD_MAX, "handler id out of range")
  `EOD_ASSERT(a_in_load, clk_i, rst_ni, in_fire |=> in_valid_q, "accepted transfer not held in input stage")
  `EOD_ASSERT(a_out_hold, clk_i, rst_ni, out_valid_q && !m_axis_tready_i |=> out_valid_q && $stable(res_q), "stalled result lost or changed")
  `EOD_ASSERT_ALWAYS(a_reset_empty, clk_i, !rst_ni |-> !out_valid_q && !in_valid_q, "stages not empty in reset")

endmodule
